// ===== src/rprop_weight_update_assert.svh =====
// Assertion macros for the weight update block.
`ifndef RPROP_WEIGHT_UPDATE_ASSERT_SVH
`define RPROP_WEIGHT_UPDATE_ASSERT_SVH

// Same-cycle implication, off while reset is low.
`define RPWU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is low.
`define RPWU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/rpwu_pkg.sv =====
package rpwu_pkg;

    localparam int NUM_WEIGHTS = 4096;
    localparam int ADDR_W      = $clog2(NUM_WEIGHTS);

    localparam int INDEX_W  = 12;
    localparam int WEIGHT_W = 32;
    localparam int STEP_W   = 30;
    localparam int CHANGE_W = 31;
    localparam int SIGN_W   = 2;
    localparam int GROW_W   = 18;
    localparam int SHRINK_W = 16;
    localparam int FRAC_W   = 16;
    localparam int PROD_W   = STEP_W + GROW_W;
    localparam int CFG_W    = 30;
    localparam int CFG_IDX_W = 3;

    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = {1'b0, {(WEIGHT_W-1){1'b1}}};
    localparam logic [WEIGHT_W-1:0] WEIGHT_MIN = {1'b1, {(WEIGHT_W-1){1'b0}}};

    localparam logic [SIGN_W-1:0] SGN_ZERO = 2'b00;
    localparam logic [SIGN_W-1:0] SGN_POS  = 2'b01;
    localparam logic [SIGN_W-1:0] SGN_NEG  = 2'b11;

    localparam logic [CFG_IDX_W-1:0] CFG_GROW      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHRINK    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_MAX  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_MIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_INIT = 3'd4;

    localparam logic [GROW_W-1:0]   GROW_RST      = 18'd78643;
    localparam logic [SHRINK_W-1:0] SHRINK_RST    = 16'd32768;
    localparam logic [STEP_W-1:0]   STEP_MAX_RST  = 30'd838860800;
    localparam logic [STEP_W-1:0]   STEP_MIN_RST  = 30'd17;
    localparam logic [STEP_W-1:0]   STEP_INIT_RST = 30'd167772;

    typedef enum logic [1:0] {
        MODE_LOAD,
        MODE_GROW,
        MODE_SHRINK,
        MODE_KEEP
    } t_mode;

    typedef struct packed {
        logic                       action;
        logic [INDEX_W-1:0]         index;
        logic signed [WEIGHT_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic [INDEX_W-1:0]         entry;
        logic signed [WEIGHT_W-1:0] weight;
        logic [STEP_W-1:0]          step;
        logic                       reverted;
    } t_out;

    typedef struct packed {
        logic [SIGN_W-1:0]   sgn;
        logic [CHANGE_W-1:0] last;
        logic [STEP_W-1:0]   step;
        logic [WEIGHT_W-1:0] weight;
    } t_entry;

endpackage

// ===== src/rpwu_entry_ram.sv =====
module rpwu_entry_ram (
    input  logic                   i_clk,
    input  logic                   i_rd_en,
    input  logic [rpwu_pkg::ADDR_W-1:0] i_rd_addr,
    output rpwu_pkg::t_entry       o_rd_data,
    input  logic                   i_wr_en,
    input  logic [rpwu_pkg::ADDR_W-1:0] i_wr_addr,
    input  rpwu_pkg::t_entry       i_wr_data
);
    import rpwu_pkg::*;

    t_entry r_mem [NUM_WEIGHTS];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/rprop_weight_update.sv =====
// Channel   Direction  Handshake                  Payload
// in        input      i_in_valid / o_in_ready    i_in  (action, index, value)
// out       output     o_out_valid / i_out_ready  o_out (entry, weight, step, reverted)
// cfg       input      i_cfg_we                   i_cfg_index, i_cfg_data
//
// One item per cycle while the output does not stall and no in-flight entry blocks it; a result passes through
// registers A, B, C, D and the output register after its transfer. Stages: table read, step multiply, step clamp,
// change select, saturating add with table write-back, output register.
// An item whose entry is still in flight in stages A to D waits until that entry is written back.
// Reset clears valids and config; the table holds no reset state.
// Any stage holds under stall; bubbles close up behind a full output register.
module rprop_weight_update (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  rpwu_pkg::t_in                      i_in,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output rpwu_pkg::t_out                     o_out,
    input  logic                               i_cfg_we,
    input  logic [rpwu_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rpwu_pkg::CFG_W-1:0]         i_cfg_data
);
    import rpwu_pkg::*;

    // config
    logic [GROW_W-1:0]   r_cfg_grow;
    logic [SHRINK_W-1:0] r_cfg_shrink;
    logic [STEP_W-1:0]   r_cfg_step_max;
    logic [STEP_W-1:0]   r_cfg_step_min;
    logic [STEP_W-1:0]   r_cfg_step_init;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_grow      <= GROW_RST;
            r_cfg_shrink    <= SHRINK_RST;
            r_cfg_step_max  <= STEP_MAX_RST;
            r_cfg_step_min  <= STEP_MIN_RST;
            r_cfg_step_init <= STEP_INIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_GROW:      r_cfg_grow      <= i_cfg_data[GROW_W-1:0];
                CFG_SHRINK:    r_cfg_shrink    <= i_cfg_data[SHRINK_W-1:0];
                CFG_STEP_MAX:  r_cfg_step_max  <= i_cfg_data[STEP_W-1:0];
                CFG_STEP_MIN:  r_cfg_step_min  <= i_cfg_data[STEP_W-1:0];
                CFG_STEP_INIT: r_cfg_step_init <= i_cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // stage registers
    logic                r_a_v, r_b_v, r_c_v, r_d_v, r_o_v;
    logic                r_a_act;
    logic [ADDR_W-1:0]   r_a_addr, r_b_addr, r_c_addr, r_d_addr;
    logic [WEIGHT_W-1:0] r_a_val;

    t_mode               r_b_mode, r_c_mode;
    logic                r_b_pos, r_b_neg, r_c_pos, r_c_neg;
    logic [WEIGHT_W-1:0] r_b_weight, r_c_weight, r_d_weight;
    logic [CHANGE_W-1:0] r_b_last, r_c_last, r_d_last;
    logic [STEP_W-1:0]   r_b_step, r_c_step, r_d_step;
    logic [PROD_W-1:0]   r_b_prod;
    logic [WEIGHT_W-1:0] r_d_delta;
    logic [SIGN_W-1:0]   r_d_sgn;
    logic                r_d_rev;
    t_out                r_o;

    logic rdy_o, rdy_d, rdy_c, rdy_b, rdy_a;
    logic in_xfer, hazard;
    logic [ADDR_W-1:0] in_addr;

    assign rdy_o = !r_o_v || i_out_ready;
    assign rdy_d = !r_d_v || rdy_o;
    assign rdy_c = !r_c_v || rdy_d;
    assign rdy_b = !r_b_v || rdy_c;
    assign rdy_a = !r_a_v || rdy_b;

    assign in_addr = i_in.index[ADDR_W-1:0];
    // same entry still ahead of write-back
    assign hazard = (r_a_v && r_a_addr == in_addr) || (r_b_v && r_b_addr == in_addr)
                 || (r_c_v && r_c_addr == in_addr) || (r_d_v && r_d_addr == in_addr);

    assign o_in_ready = rdy_a && !hazard;
    assign in_xfer    = i_in_valid && o_in_ready;

    // entry table
    t_entry rd_data, wr_data;
    logic   wr_en;

    rpwu_entry_ram u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (in_xfer),
        .i_rd_addr (in_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_d_addr),
        .i_wr_data (wr_data)
    );

    // stage A: classify, multiply
    logic              a_g_pos, a_g_neg, a_p_pos, a_p_neg;
    t_mode             a_mode;
    logic [GROW_W-1:0] a_factor;
    logic [PROD_W-1:0] a_prod;

    always_comb begin
        a_g_pos = !r_a_val[WEIGHT_W-1] && (r_a_val != '0);
        a_g_neg = r_a_val[WEIGHT_W-1];
        a_p_pos = rd_data.sgn == SGN_POS;
        a_p_neg = rd_data.sgn == SGN_NEG;
        if (!r_a_act) begin
            a_mode = MODE_LOAD;
        end else if ((a_p_pos && a_g_pos) || (a_p_neg && a_g_neg)) begin
            a_mode = MODE_GROW;
        end else if ((a_p_pos && a_g_neg) || (a_p_neg && a_g_pos)) begin
            a_mode = MODE_SHRINK;
        end else begin
            a_mode = MODE_KEEP;
        end
        a_factor = (a_mode == MODE_SHRINK) ? GROW_W'(r_cfg_shrink) : r_cfg_grow;
        a_prod   = PROD_W'(rd_data.step) * PROD_W'(a_factor);
    end

    // stage B: scale, clamp
    logic [WEIGHT_W-1:0] b_scaled, b_max, b_min;
    logic [STEP_W-1:0]   b_step;

    always_comb begin
        b_scaled = r_b_prod[FRAC_W +: WEIGHT_W];
        b_max    = WEIGHT_W'(r_cfg_step_max);
        b_min    = WEIGHT_W'(r_cfg_step_min);
        case (r_b_mode)
            MODE_LOAD: b_step = r_cfg_step_init;
            MODE_GROW: b_step = (b_scaled > b_max) ? r_cfg_step_max : b_scaled[STEP_W-1:0];
            MODE_SHRINK: begin
                if (b_scaled < b_min) begin
                    b_step = r_cfg_step_min;
                end else if (b_scaled > b_max) begin
                    b_step = r_cfg_step_max;
                end else begin
                    b_step = b_scaled[STEP_W-1:0];
                end
            end
            default: b_step = r_b_step;
        endcase
    end

    // stage C: weight change
    logic [WEIGHT_W-1:0] c_delta;
    logic [CHANGE_W-1:0] c_last;
    logic [SIGN_W-1:0]   c_sgn;

    always_comb begin
        c_delta = '0;
        c_last  = r_c_last;
        c_sgn   = SGN_ZERO;
        case (r_c_mode)
            MODE_LOAD: begin
                c_last = CHANGE_W'(r_c_step);
            end
            MODE_SHRINK: begin
                c_delta = -{r_c_last[CHANGE_W-1], r_c_last};
            end
            default: begin
                if (r_c_pos) begin
                    c_delta = -WEIGHT_W'(r_c_step);
                    c_sgn   = SGN_POS;
                end else if (r_c_neg) begin
                    c_delta = WEIGHT_W'(r_c_step);
                    c_sgn   = SGN_NEG;
                end
                c_last = c_delta[CHANGE_W-1:0];
            end
        endcase
    end

    // stage D: saturating add, write-back
    logic [WEIGHT_W:0]   d_sum;
    logic [WEIGHT_W-1:0] d_weight;

    always_comb begin
        d_sum = {r_d_weight[WEIGHT_W-1], r_d_weight} + {r_d_delta[WEIGHT_W-1], r_d_delta};
        if (d_sum[WEIGHT_W] != d_sum[WEIGHT_W-1]) begin
            d_weight = d_sum[WEIGHT_W] ? WEIGHT_MIN : WEIGHT_MAX;
        end else begin
            d_weight = d_sum[WEIGHT_W-1:0];
        end
        wr_data.sgn    = r_d_sgn;
        wr_data.last   = r_d_last;
        wr_data.step   = r_d_step;
        wr_data.weight = d_weight;
    end

    assign wr_en = r_d_v && rdy_o;

    // valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            r_o_v <= 1'b0;
        end else begin
            if (rdy_a) r_a_v <= in_xfer;
            if (rdy_b) r_b_v <= r_a_v;
            if (rdy_c) r_c_v <= r_b_v;
            if (rdy_d) r_d_v <= r_c_v;
            if (rdy_o) r_o_v <= r_d_v;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_a_act  <= i_in.action;
            r_a_addr <= in_addr;
            r_a_val  <= i_in.value;
        end
        if (rdy_b && r_a_v) begin
            r_b_mode   <= a_mode;
            r_b_addr   <= r_a_addr;
            r_b_pos    <= a_g_pos;
            r_b_neg    <= a_g_neg;
            r_b_weight <= r_a_act ? rd_data.weight : r_a_val;
            r_b_last   <= rd_data.last;
            r_b_step   <= rd_data.step;
            r_b_prod   <= a_prod;
        end
        if (rdy_c && r_b_v) begin
            r_c_mode   <= r_b_mode;
            r_c_addr   <= r_b_addr;
            r_c_pos    <= r_b_pos;
            r_c_neg    <= r_b_neg;
            r_c_weight <= r_b_weight;
            r_c_last   <= r_b_last;
            r_c_step   <= b_step;
        end
        if (rdy_d && r_c_v) begin
            r_d_addr   <= r_c_addr;
            r_d_weight <= r_c_weight;
            r_d_delta  <= c_delta;
            r_d_last   <= c_last;
            r_d_step   <= r_c_step;
            r_d_sgn    <= c_sgn;
            r_d_rev    <= r_c_mode == MODE_SHRINK;
        end
        if (wr_en) begin
            r_o.entry    <= INDEX_W'(r_d_addr);
            r_o.weight   <= d_weight;
            r_o.step     <= r_d_step;
            r_o.reverted <= r_d_rev;
        end
    end

    assign o_out_valid = r_o_v;
    assign o_out       = r_o;

endmodule

// ===== src/rpwu_checker.sv =====
`include "rprop_weight_update_assert.svh"

module rpwu_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input rpwu_pkg::t_in  i_in,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input rpwu_pkg::t_out o_out
);
    import rpwu_pkg::*;

    `RPWU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out), "result changed while stalled")

    `RPWU_ASSERT_NOW(a_reset_empty, i_clk, i_rst_n, !$past(i_rst_n), !o_out_valid, "result shown right after reset")

    // an entry still in flight blocks a second transfer to it
    `RPWU_ASSERT_NOW(a_same_entry_wait, i_clk, i_rst_n, $past(i_rst_n) && $past(i_in_valid && o_in_ready) && i_in_valid && (i_in.index == $past(i_in.index)), !o_in_ready, "back-to-back transfer to one entry")

endmodule

bind rprop_weight_update rpwu_checker u_rpwu_checker (.*);

// ===== tb/rprop_weight_update_tb.sv =====
module rprop_weight_update_tb;
    import rpwu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_APPLY   = 1'b1;
    localparam int   HOLD_CYCLES = 300;
    localparam int   NUM_CFG     = 5;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_ready;
    t_in                    i_in;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    t_out                   o_out;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_W-1:0]       i_cfg_data;

    rprop_weight_update u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // predictor copy of the configuration and the weight table
    logic [GROW_W-1:0]            cfg_grow      = GROW_RST;
    logic [SHRINK_W-1:0]          cfg_shrink    = SHRINK_RST;
    logic [STEP_W-1:0]            cfg_step_max  = STEP_MAX_RST;
    logic [STEP_W-1:0]            cfg_step_min  = STEP_MIN_RST;
    logic [STEP_W-1:0]            cfg_step_init = STEP_INIT_RST;

    logic signed [WEIGHT_W-1:0]   weight_tbl [NUM_WEIGHTS];
    logic [STEP_W-1:0]            step_tbl   [NUM_WEIGHTS];
    logic signed [CHANGE_W-1:0]   change_tbl [NUM_WEIGHTS];
    logic [SIGN_W-1:0]            sign_tbl   [NUM_WEIGHTS];

    t_out expected_updates [$];
    int   error_count = 0;

    // stimulus bookkeeping
    bit   loaded [NUM_WEIGHTS];
    int   loaded_list [$];
    int   grad_dir [NUM_WEIGHTS];
    int   burst_left = 0;

    // receiver
    logic long_hold_req = 1'b0;
    int   hold_left = 0;
    int   ready_pct = 100;
    int   pattern_left = 0;
    t_out captured;

    function automatic logic signed [WEIGHT_W-1:0] sat_add(
        input logic signed [WEIGHT_W-1:0] w, input longint delta);
        longint s;
        s = longint'(w) + delta;
        if (s > longint'($signed(WEIGHT_MAX))) return WEIGHT_MAX;
        if (s < longint'($signed(WEIGHT_MIN))) return WEIGHT_MIN;
        return s[WEIGHT_W-1:0];
    endfunction

    function automatic void apply_config(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_W-1:0] data);
        case (idx)
            CFG_GROW:      cfg_grow      = data[GROW_W-1:0];
            CFG_SHRINK:    cfg_shrink    = data[SHRINK_W-1:0];
            CFG_STEP_MAX:  cfg_step_max  = data[STEP_W-1:0];
            CFG_STEP_MIN:  cfg_step_min  = data[STEP_W-1:0];
            CFG_STEP_INIT: cfg_step_init = data[STEP_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic t_out predict_update(input t_in item);
        t_out                res;
        int                  idx;
        logic [SIGN_W-1:0]   g;
        logic [SIGN_W-1:0]   p;
        logic [PROD_W-1:0]   scaled;
        logic [STEP_W-1:0]   st;
        longint              move;
        idx = int'(item.index) % NUM_WEIGHTS;
        res.reverted = 1'b0;
        if (item.action == ACT_LOAD) begin
            weight_tbl[idx] = item.value;
            step_tbl[idx]   = cfg_step_init;
            change_tbl[idx] = {1'b0, cfg_step_init};
            sign_tbl[idx]   = SGN_ZERO;
        end else begin
            if ($signed(item.value) > 0)
                g = SGN_POS;
            else if ($signed(item.value) < 0)
                g = SGN_NEG;
            else
                g = SGN_ZERO;
            p  = sign_tbl[idx];
            st = step_tbl[idx];
            if (g != SGN_ZERO && p == g) begin
                scaled = (PROD_W'(st) * PROD_W'(cfg_grow)) >> FRAC_W;
                st = (scaled > PROD_W'(cfg_step_max)) ? cfg_step_max : scaled[STEP_W-1:0];
                move = (g == SGN_POS) ? -longint'(st) : longint'(st);
                weight_tbl[idx] = sat_add(weight_tbl[idx], move);
                change_tbl[idx] = move[CHANGE_W-1:0];
                sign_tbl[idx]   = g;
            end else if (g != SGN_ZERO && p != SGN_ZERO) begin
                scaled = (PROD_W'(st) * PROD_W'(cfg_shrink)) >> FRAC_W;
                if (scaled < PROD_W'(cfg_step_min))
                    st = cfg_step_min;
                else if (scaled > PROD_W'(cfg_step_max))
                    st = cfg_step_max;
                else
                    st = scaled[STEP_W-1:0];
                weight_tbl[idx] = sat_add(weight_tbl[idx], -longint'(change_tbl[idx]));
                sign_tbl[idx]   = SGN_ZERO;
                res.reverted    = 1'b1;
            end else begin
                if (g == SGN_POS)
                    move = -longint'(st);
                else if (g == SGN_NEG)
                    move = longint'(st);
                else
                    move = 0;
                weight_tbl[idx] = sat_add(weight_tbl[idx], move);
                change_tbl[idx] = move[CHANGE_W-1:0];
                sign_tbl[idx]   = g;
            end
            step_tbl[idx] = st;
        end
        res.entry  = idx[INDEX_W-1:0];
        res.weight = weight_tbl[idx];
        res.step   = step_tbl[idx];
        return res;
    endfunction

    function automatic void note_error(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("MISMATCH @%0t: %s", $time, msg);
    endfunction

    task automatic check_update(input t_out got);
        t_out exp;
        if (expected_updates.size() == 0) begin
            note_error($sformatf("unexpected result for entry %0d", got.entry));
            return;
        end
        exp = expected_updates.pop_front();
        if (got.entry !== exp.entry)
            note_error($sformatf("entry exp %0d got %0d", exp.entry, got.entry));
        if (got.weight !== exp.weight)
            note_error($sformatf("entry %0d weight exp %h got %h",
                                 exp.entry, exp.weight, got.weight));
        if (got.step !== exp.step)
            note_error($sformatf("entry %0d step exp %h got %h",
                                 exp.entry, exp.step, got.step));
        if (got.reverted !== exp.reverted)
            note_error($sformatf("entry %0d reverted exp %b got %b",
                                 exp.entry, exp.reverted, got.reverted));
    endtask

    // outputs sampled mid-cycle; the transfer completes on the next rising edge
    always begin
        @(negedge i_clk);
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
            captured = o_out;
            @(posedge i_clk);
            check_update(captured);
        end
    end

    always @(posedge i_clk) begin
        if (long_hold_req)
            hold_left = HOLD_CYCLES;
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            if (pattern_left == 0) begin
                ready_pct    = 25 * $urandom_range(1, 4);
                pattern_left = $urandom_range(10, 80);
            end
            pattern_left--;
            i_out_ready <= ($urandom_range(1, 100) <= ready_pct);
        end
    end

    task automatic send_item(input t_in item);
        int gap_cycles;
        bit took;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap_cycles > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap_cycles) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in       <= item;
        do begin
            @(negedge i_clk);
            took = o_in_ready;
            @(posedge i_clk);
        end while (!took);
        expected_updates.push_back(predict_update(item));
    endtask

    task automatic load_entry(input int idx, input logic signed [WEIGHT_W-1:0] val);
        t_in item;
        item.action = ACT_LOAD;
        item.index  = idx[INDEX_W-1:0];
        item.value  = val;
        if (!loaded[idx]) begin
            loaded[idx] = 1'b1;
            loaded_list.push_back(idx);
        end
        grad_dir[idx] = 0;
        send_item(item);
    endtask

    task automatic apply_gradient(input int idx, input logic signed [WEIGHT_W-1:0] val);
        t_in item;
        item.action = ACT_APPLY;
        item.index  = idx[INDEX_W-1:0];
        item.value  = val;
        send_item(item);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_updates.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [GROW_W-1:0] grow,
                                input logic [SHRINK_W-1:0] shrink,
                                input logic [STEP_W-1:0] smax,
                                input logic [STEP_W-1:0] smin,
                                input logic [STEP_W-1:0] sinit);
        logic [CFG_W-1:0]     junk;
        logic [CFG_W-1:0]     data [NUM_CFG];
        logic [CFG_IDX_W-1:0] regs [NUM_CFG];
        logic [CFG_IDX_W-1:0] spare_idx;
        wait_idle();
        junk = CFG_W'($urandom);
        regs = '{CFG_GROW, CFG_SHRINK, CFG_STEP_MAX, CFG_STEP_MIN, CFG_STEP_INIT};
        data = '{{junk[CFG_W-1:GROW_W], grow}, {junk[CFG_W-1:SHRINK_W], shrink},
                 smax, smin, sinit};
        for (int r = 0; r < NUM_CFG; r++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= regs[r];
            i_cfg_data  <= data[r];
            @(posedge i_clk);
            apply_config(regs[r], data[r]);
        end
        // index past the register list must be ignored
        spare_idx = CFG_IDX_W'($urandom_range(int'(CFG_STEP_INIT) + 1, (1 << CFG_IDX_W) - 1));
        junk = CFG_W'($urandom);
        i_cfg_index <= spare_idx;
        i_cfg_data  <= junk;
        @(posedge i_clk);
        apply_config(spare_idx, junk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic signed [WEIGHT_W-1:0] random_weight();
        case ($urandom_range(0, 9))
            0:       return WEIGHT_MAX - $urandom_range(0, 1 << 20);
            1:       return WEIGHT_MIN + $urandom_range(0, 1 << 20);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [WEIGHT_W-1:0] gradient_value(input int dir);
        logic [WEIGHT_W-1:0] mag;
        if (dir == 0)
            return '0;
        mag = $urandom >> 1;
        if (mag == 0)
            mag = 1;
        if ($urandom_range(0, 19) == 0)
            mag = WEIGHT_MAX;
        if (dir > 0)
            return mag;
        if ($urandom_range(0, 19) == 0)
            return WEIGHT_MIN;
        return -mag;
    endfunction

    // well-formed load/apply sequences; a small hot set keeps entries in flight
    task automatic run_traffic(input int count, input int hot_count);
        int hot [$];
        int idx;
        int r;
        int dir;
        repeat (hot_count) begin
            idx = $urandom_range(0, NUM_WEIGHTS - 1);
            hot.push_back(idx);
            load_entry(idx, random_weight());
        end
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < 12) begin
                load_entry($urandom_range(0, NUM_WEIGHTS - 1), random_weight());
            end else begin
                if (r < 60)
                    idx = hot[$urandom_range(0, hot.size() - 1)];
                else
                    idx = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
                dir = grad_dir[idx];
                if (dir == 0)
                    dir = $urandom_range(0, 1) ? 1 : -1;
                r = $urandom_range(0, 99);
                if (r >= 85)
                    dir = 0;
                else if (r >= 60)
                    dir = -dir;
                if (dir != 0)
                    grad_dir[idx] = dir;
                apply_gradient(idx, gradient_value(dir));
            end
        end
    endtask

    task automatic test_directed();
        load_entry(0, WEIGHT_MAX);
        load_entry(NUM_WEIGHTS - 1, WEIGHT_MIN);
        load_entry(1, 0);
        apply_gradient(0, WEIGHT_MIN);
        apply_gradient(0, WEIGHT_MIN + 1);
        apply_gradient(0, WEIGHT_MAX);
        apply_gradient(0, 0);
        apply_gradient(NUM_WEIGHTS - 1, 1);
        apply_gradient(NUM_WEIGHTS - 1, WEIGHT_MAX);
        apply_gradient(NUM_WEIGHTS - 1, -1);
        apply_gradient(NUM_WEIGHTS - 1, -5);
        apply_gradient(1, 1);
        apply_gradient(1, 2);
        apply_gradient(1, 3);
        apply_gradient(1, -7);
        apply_gradient(1, -7);
        apply_gradient(1, 0);
        apply_gradient(1, 9);
        load_entry(1, 32'h00FF00FF);
        apply_gradient(1, 32'h40000000);
        load_entry('hAAA, 32'h55555555);
        load_entry('h555, 32'hAAAAAAAA);
        apply_gradient('hAAA, 32'h55555555);
        apply_gradient('h555, 32'hAAAAAAAA);
    endtask

    task automatic test_config_sweep();
        write_config('1, '1, '1, '0, '1);
        run_traffic(50, 6);
        write_config('0, '0, '0, '0, '0);
        run_traffic(50, 6);
        // step_min above step_max
        write_config(GROW_RST, 16'hFFFF, 30'd100000, 30'd500000, 30'd900000);
        run_traffic(50, 6);
        write_config(18'd65536, '0, 30'd536870912, 30'd1000, 30'd5000);
        run_traffic(50, 6);
        write_config(GROW_W'($urandom_range(65536, 262143)), SHRINK_W'($urandom),
                     STEP_W'($urandom_range(1 << 20, 1 << 28)),
                     STEP_W'($urandom_range(0, 1 << 16)),
                     STEP_W'($urandom_range(0, 1 << 24)));
        run_traffic(50, 6);
    endtask

    task automatic test_random_traffic();
        write_config(GROW_RST, SHRINK_RST, 30'd16777216, STEP_MIN_RST, STEP_INIT_RST);
        run_traffic(250, 8);
        write_config(GROW_RST, SHRINK_RST, STEP_MAX_RST, STEP_MIN_RST, STEP_INIT_RST);
        run_traffic(250, 8);
    endtask

    task automatic test_backpressure();
        wait_idle();
        long_hold_req <= 1'b1;
        @(posedge i_clk);
        long_hold_req <= 1'b0;
        run_traffic(40, 4);
        wait_idle();
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in        = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_GROW;
        i_cfg_data  = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_config_sweep();
        test_random_traffic();
        test_backpressure();
        wait_idle();
        if (error_count == 0 && expected_updates.size() == 0)
            $display("rprop_weight_update test passed");
        else
            $display("rprop_weight_update test failed");
        $finish;
    end

    initial begin
        #5000000;
        $display("rprop_weight_update test failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/rpwu_pkg.sv
src/rpwu_entry_ram.sv
src/rprop_weight_update.sv
src/rpwu_checker.sv
tb/rprop_weight_update_tb.sv
